### rtl/pure_pursuit_path_follower_top_assert.svh
// ----------------------------------------------------------------------------
// Pure pursuit follower assertion macros
// Shared shorthand for the concurrent checks on the follower's ports.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_PATH_FOLLOWER_TOP_ASSERT_SVH
`define PURE_PURSUIT_PATH_FOLLOWER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pure pursuit follower check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pure pursuit follower check failed");

`endif

### rtl/ppf_pkg.sv
// ----------------------------------------------------------------------------
// Pure pursuit follower package
// Sizes, codes and the arctangent table shared by the follower files.
// ----------------------------------------------------------------------------
package ppf_pkg;

    localparam int PATH_DEPTH       = 1024;
    localparam int ADDR_W           = $clog2(PATH_DEPTH);
    localparam int LEN_W            = ADDR_W + 1;
    localparam int ANGLE_ITERATIONS = 16;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_CLEAR  = 2'd0;
    localparam t_opcode OP_APPEND = 2'd1;
    localparam t_opcode OP_TICK   = 2'd2;

    typedef logic [3:0] t_status;
    localparam t_status ST_DRIVE     = 4'd0;
    localparam t_status ST_NO_PATH   = 4'd1;
    localparam t_status ST_STALE     = 4'd2;
    localparam t_status ST_NO_POSE   = 4'd3;
    localparam t_status ST_GOAL      = 4'd4;
    localparam t_status ST_OBSTACLE  = 4'd5;
    localparam t_status ST_TOO_CLOSE = 4'd6;
    localparam t_status ST_STORED    = 4'd7;
    localparam t_status ST_DROPPED   = 4'd8;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOOKAHEAD = 3'd0;
    localparam t_cfg_idx CFG_MAX_LIN   = 3'd1;
    localparam t_cfg_idx CFG_MAX_TURN  = 3'd2;
    localparam t_cfg_idx CFG_GOAL_RAD  = 3'd3;
    localparam t_cfg_idx CFG_STALE     = 3'd4;

    localparam logic signed [21:0] Q_PI         = 22'sd205887;
    localparam logic signed [21:0] Q_TWO_PI     = 22'sd411775;
    localparam logic signed [21:0] Q_HALF_PI    = 22'sd102944;
    localparam logic signed [21:0] Q_QUARTER_PI = 22'sd51472;
    localparam logic [33:0]        Q_MIN_LOOK   = 34'd655;
    localparam logic [20:0]        Q_CREEP      = 21'd6554;
    localparam logic [33:0]        Q_ONE        = 34'd65536;
    localparam logic signed [37:0] CORDIC_GAIN  = 38'sd652032874;

    // Arctangent of 2^-i in Q16, rounded; zero from step 17 on.
    function automatic logic [16:0] atan_entry(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/pure_pursuit_path_follower_top.sv
// ----------------------------------------------------------------------------
// Pure pursuit path follower
// Loads path points into on-chip memory and turns robot poses into clamped
// linear and angular speed commands, or into a stop reason.
// ----------------------------------------------------------------------------
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+------------------
//  command   | i_opcode i_pos_x i_pos_y i_heading i_pose_valid | start & !busy
//            | i_obstacle_ahead                               |
//  result    | o_linear_cmd o_angular_cmd o_status            | o_valid, 1 cycle
//  config    | i_cfg_idx i_cfg_data                           | i_cfg_we
//
// Clear and append beats finish in S_IDLE; the result is registered and
// follows on the next clock. A tick that stops early on an age, pose or path
// check also answers from S_IDLE. A full tick measures the goal point, then each
// stored point for the closest-point scan (dx and dy squared in turn, then a
// bit-serial square root), reads one stored distance per cycle in the lookahead
// scan, and runs 2 x ANGLE_ITERATIONS CORDIC steps and 53 divider steps. busy is
// high for the whole tick; the result beat cannot be stalled. Reset sets the
// state, path length, age, valid and config registers; memories need no clearing.
// ----------------------------------------------------------------------------
module pure_pursuit_path_follower_top
    import ppf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [18:0] i_heading,
    input  logic               i_pose_valid,
    input  logic               i_obstacle_ahead,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [22:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [20:0] o_linear_cmd,
    output logic signed [21:0] o_angular_cmd,
    output logic [3:0]         o_status
);

    // One-hot sequencer. Every distance goes through S_DRD..S_DDONE; the
    // r_scan flag tells S_DDONE whether it measured the goal or a scan point.
    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_DRD   = 17'b00000000000000010,
        S_MUL1  = 17'b00000000000000100,
        S_MUL2  = 17'b00000000000001000,
        S_SQRT  = 17'b00000000000010000,
        S_DDONE = 17'b00000000000100000,
        S_S2A   = 17'b00000000001000000,
        S_S2    = 17'b00000000010000000,
        S_LRD   = 17'b00000000100000000,
        S_ATAN  = 17'b00000001000000000,
        S_ALPHA = 17'b00000010000000000,
        S_SIN   = 17'b00000100000000000,
        S_SPD1  = 17'b00001000000000000,
        S_SPD2  = 17'b00010000000000000,
        S_MULS  = 17'b00100000000000000,
        S_DIV   = 17'b01000000000000000,
        S_FIN   = 17'b10000000000000000
    } t_state;

    // Point memories and a scratch memory of per-point distances.
    logic [31:0] r_mem_x [PATH_DEPTH];
    logic [31:0] r_mem_y [PATH_DEPTH];
    logic [33:0] r_mem_d [PATH_DEPTH];

    t_state r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0] r_age, n_age;
    logic [22:0] r_la, r_gr;
    logic [19:0] r_mls;
    logic [20:0] r_mtr;
    logic [15:0] r_stale;

    logic signed [31:0] r_px, n_px, r_py, n_py;
    logic signed [18:0] r_hd, n_hd;
    logic r_obst, n_obst;

    logic [31:0] r_xq, r_yq;
    logic [33:0] r_dq;

    logic [31:0] r_ax, n_ax, r_ay, n_ay;
    logic r_sh, n_sh;
    logic [63:0] r_sq, n_sq;
    logic [65:0] r_rad, n_rad;
    logic [36:0] r_rem, n_rem;
    logic [32:0] r_root, n_root;
    logic [5:0] r_cnt, n_cnt;

    logic r_scan, n_scan;
    logic [ADDR_W-1:0] r_idx, n_idx, r_close, n_close;
    logic [33:0] r_best, n_best, r_dgoal, n_dgoal, r_lval, n_lval;

    logic signed [37:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [21:0] r_cz, n_cz, r_alpha, n_alpha;

    logic [36:0] r_prod, n_prod;
    logic [19:0] r_lin, n_lin;
    logic r_sneg, n_sneg;
    logic [52:0] r_num, n_num, r_q, n_q;
    logic [48:0] r_drem, n_drem;

    logic r_valid, n_valid;
    logic [20:0] r_olin, n_olin;
    logic [21:0] r_oang, n_oang;
    t_status r_ost, n_ost;

    // Memory ports.
    logic mem_we, dist_we;
    logic [ADDR_W-1:0] mem_wa, rd_a, dist_wa, dist_ra;
    logic [33:0] dist_wd;

    // Datapath helpers.
    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic big;
    logic [36:0] rem_s, trial;
    logic [33:0] pt_dist;
    logic [15:0] age_new;
    logic [ADDR_W-1:0] last_idx;
    logic signed [37:0] xs, ys;
    logic signed [21:0] z_step, a_raw, a_wrap, a_fold;
    logic [20:0] lin_a, lin_b;
    logic [37:0] cy_abs;
    logic [48:0] rs, den;
    logic [52:0] mag_cmp;
    logic [20:0] mag;

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_linear_cmd  = $signed(r_olin);
    assign o_angular_cmd = $signed(r_oang);
    assign o_status      = r_ost;

    assign last_idx = ADDR_W'(r_len - LEN_W'(1));

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[mem_wa] <= i_pos_x;
            r_mem_y[mem_wa] <= i_pos_y;
        end
        r_xq <= r_mem_x[rd_a];
        r_yq <= r_mem_y[rd_a];
        if (dist_we) begin
            r_mem_d[dist_wa] <= dist_wd;
        end
        r_dq <= r_mem_d[dist_ra];
    end

    always_comb begin
        // Offsets from the robot to the point just read, for distance and angle.
        dx  = $signed({r_xq[31], r_xq}) - $signed({r_px[31], r_px});
        dy  = $signed({r_yq[31], r_yq}) - $signed({r_py[31], r_py});
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
        big = adx[32] | adx[31] | ady[32] | ady[31];

        // One digit of the square root per cycle.
        rem_s   = {r_rem[34:0], r_rad[65:64]};
        trial   = {2'b00, r_root, 2'b01};
        pt_dist = r_sh ? {r_root, 1'b0} : {1'b0, r_root};

        age_new = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;

        // Shared CORDIC step terms.
        xs     = r_cx >>> r_cnt;
        ys     = r_cy >>> r_cnt;
        z_step = $signed(22'(atan_entry(r_cnt[4:0])));

        // Heading error wrapped once into [-pi, pi], then folded for sine.
        a_raw = r_cz - 22'(r_hd);
        if (a_raw > Q_PI) begin
            a_wrap = a_raw - Q_TWO_PI;
        end else if (a_raw < -Q_PI) begin
            a_wrap = a_raw + Q_TWO_PI;
        end else begin
            a_wrap = a_raw;
        end
        if (a_wrap > Q_HALF_PI) begin
            a_fold = Q_PI - a_wrap;
        end else if (a_wrap < -Q_HALF_PI) begin
            a_fold = -Q_PI - a_wrap;
        end else begin
            a_fold = a_wrap;
        end

        // Speed shaping: goal slowdown with creep floor, half speed on sharp turns.
        if (r_dgoal < Q_ONE) begin
            lin_a = (r_prod[36:16] < Q_CREEP) ? Q_CREEP : r_prod[36:16];
        end else begin
            lin_a = {1'b0, r_mls};
        end
        lin_b = ((r_alpha > Q_QUARTER_PI) || (r_alpha < -Q_QUARTER_PI)) ? (lin_a >> 1) : lin_a;

        cy_abs = r_cy[37] ? 38'(-r_cy) : 38'(r_cy);

        // Restoring divider, one quotient bit per cycle.
        den = {1'b0, r_lval, 14'd0};
        rs  = {r_drem[47:0], r_num[52]};

        mag_cmp = r_q;
        mag     = (mag_cmp > 53'(r_mtr)) ? r_mtr : mag_cmp[20:0];
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_age   = r_age;
        n_px    = r_px;
        n_py    = r_py;
        n_hd    = r_hd;
        n_obst  = r_obst;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_sh    = r_sh;
        n_sq    = r_sq;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_scan  = r_scan;
        n_idx   = r_idx;
        n_close = r_close;
        n_best  = r_best;
        n_dgoal = r_dgoal;
        n_lval  = r_lval;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_alpha = r_alpha;
        n_prod  = r_prod;
        n_lin   = r_lin;
        n_sneg  = r_sneg;
        n_num   = r_num;
        n_q     = r_q;
        n_drem  = r_drem;
        n_valid = 1'b0;
        n_olin  = '0;
        n_oang  = '0;
        n_ost   = r_ost;
        mem_we  = 1'b0;
        mem_wa  = r_len[ADDR_W-1:0];
        rd_a    = r_idx;
        dist_we = 1'b0;
        dist_wa = r_idx;
        dist_wd = pt_dist;
        dist_ra = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    priority case (i_opcode)
                        OP_CLEAR: begin
                            n_len   = '0;
                            n_age   = '0;
                            n_valid = 1'b1;
                            n_ost   = ST_STORED;
                        end
                        OP_APPEND: begin
                            n_valid = 1'b1;
                            if (r_len[LEN_W-1]) begin
                                n_ost = ST_DROPPED;
                            end else begin
                                mem_we = 1'b1;
                                n_len  = r_len + LEN_W'(1);
                                n_ost  = ST_STORED;
                            end
                        end
                        OP_TICK: begin
                            n_age = age_new;
                            if (r_len == '0) begin
                                n_valid = 1'b1;
                                n_ost   = ST_NO_PATH;
                            end else if (age_new > r_stale) begin
                                n_valid = 1'b1;
                                n_ost   = ST_STALE;
                            end else if (!i_pose_valid) begin
                                n_valid = 1'b1;
                                n_ost   = ST_NO_POSE;
                            end else begin
                                n_px    = i_pos_x;
                                n_py    = i_pos_y;
                                n_hd    = i_heading;
                                n_obst  = i_obstacle_ahead;
                                n_scan  = 1'b0;
                                rd_a    = last_idx;
                                n_state = S_DRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DRD: begin
                n_sh    = big;
                n_ax    = big ? adx[32:1] : adx[31:0];
                n_ay    = big ? ady[32:1] : ady[31:0];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_sq    = r_ax * r_ax;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_rad   = 66'(r_sq) + 66'(r_ay * r_ay);
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = 6'd33;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (rem_s >= trial) begin
                    n_rem  = rem_s - trial;
                    n_root = {r_root[31:0], 1'b1};
                end else begin
                    n_rem  = rem_s;
                    n_root = {r_root[31:0], 1'b0};
                end
                n_rad = {r_rad[63:0], 2'b00};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                if (!r_scan) begin
                    n_dgoal = pt_dist;
                    if (pt_dist < 34'(r_gr)) begin
                        n_valid = 1'b1;
                        n_ost   = ST_GOAL;
                        n_state = S_IDLE;
                    end else if (r_obst) begin
                        n_valid = 1'b1;
                        n_ost   = ST_OBSTACLE;
                        n_state = S_IDLE;
                    end else begin
                        n_scan  = 1'b1;
                        n_idx   = '0;
                        n_close = '0;
                        n_best  = '1;
                        rd_a    = '0;
                        n_state = S_DRD;
                    end
                end else begin
                    // Keep the distance for the lookahead pass; strict compare keeps
                    // the first of equally close points.
                    dist_we = 1'b1;
                    if (pt_dist < r_best) begin
                        n_best  = pt_dist;
                        n_close = r_idx;
                    end
                    if (r_idx == last_idx) begin
                        n_idx   = (pt_dist < r_best) ? r_idx : r_close;
                        n_state = S_S2A;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        rd_a    = r_idx + ADDR_W'(1);
                        n_state = S_DRD;
                    end
                end
            end
            S_S2A: begin
                dist_ra = r_idx;
                n_state = S_S2;
            end
            S_S2: begin
                if ((r_dq >= 34'(r_la)) || (r_idx == last_idx)) begin
                    n_lval  = r_dq;
                    rd_a    = r_idx;
                    n_state = S_LRD;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    dist_ra = r_idx + ADDR_W'(1);
                end
            end
            S_LRD: begin
                if (r_lval < Q_MIN_LOOK) begin
                    n_valid = 1'b1;
                    n_ost   = ST_TOO_CLOSE;
                    n_state = S_IDLE;
                end else begin
                    if (dx[32]) begin
                        n_cz = dy[32] ? -Q_PI : Q_PI;
                        n_cx = 38'(-dx);
                        n_cy = 38'(-dy);
                    end else begin
                        n_cz = '0;
                        n_cx = 38'(dx);
                        n_cy = 38'(dy);
                    end
                    n_cnt   = '0;
                    n_state = S_ATAN;
                end
            end
            S_ATAN: begin
                if (r_cy > 38'sd0) begin
                    n_cx = r_cx + ys;
                    n_cy = r_cy - xs;
                    n_cz = r_cz + z_step;
                end else begin
                    n_cx = r_cx - ys;
                    n_cy = r_cy + xs;
                    n_cz = r_cz - z_step;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(ANGLE_ITERATIONS - 1)) begin
                    n_state = S_ALPHA;
                end
            end
            S_ALPHA: begin
                n_alpha = a_wrap;
                n_cx    = CORDIC_GAIN;
                n_cy    = '0;
                n_cz    = a_fold;
                n_cnt   = '0;
                n_state = S_SIN;
            end
            S_SIN: begin
                if (r_cz >= 22'sd0) begin
                    n_cx = r_cx - ys;
                    n_cy = r_cy + xs;
                    n_cz = r_cz - z_step;
                end else begin
                    n_cx = r_cx + ys;
                    n_cy = r_cy - xs;
                    n_cz = r_cz + z_step;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(ANGLE_ITERATIONS - 1)) begin
                    n_state = S_SPD1;
                end
            end
            S_SPD1: begin
                n_prod  = r_mls * r_dgoal[16:0];
                n_state = S_SPD2;
            end
            S_SPD2: begin
                n_lin   = (lin_b > 21'(r_mls)) ? r_mls : lin_b[19:0];
                n_sneg  = r_cy[37];
                n_state = S_MULS;
            end
            S_MULS: begin
                n_num   = {52'(r_lin) * 52'(cy_abs[31:0]), 1'b0};
                n_q     = '0;
                n_drem  = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (rs >= den) begin
                    n_drem = rs - den;
                    n_q    = {r_q[51:0], 1'b1};
                end else begin
                    n_drem = rs;
                    n_q    = {r_q[51:0], 1'b0};
                end
                n_num = {r_num[51:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd52) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_valid = 1'b1;
                n_ost   = ST_DRIVE;
                n_olin  = {1'b0, r_lin};
                n_oang  = r_sneg ? 22'(-{1'b0, mag}) : {1'b0, mag};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_age   <= '0;
            r_valid <= 1'b0;
            r_la    <= 23'd65536;
            r_mls   <= 20'd32768;
            r_mtr   <= 21'd98304;
            r_gr    <= 23'd19661;
            r_stale <= 16'd50;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_age   <= n_age;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    CFG_LOOKAHEAD: r_la    <= i_cfg_data;
                    CFG_MAX_LIN:   r_mls   <= i_cfg_data[19:0];
                    CFG_MAX_TURN:  r_mtr   <= i_cfg_data[20:0];
                    CFG_GOAL_RAD:  r_gr    <= i_cfg_data;
                    CFG_STALE:     r_stale <= i_cfg_data[15:0];
                    default:       r_stale <= r_stale;
                endcase
            end
        end
        r_px    <= n_px;
        r_py    <= n_py;
        r_hd    <= n_hd;
        r_obst  <= n_obst;
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_sh    <= n_sh;
        r_sq    <= n_sq;
        r_rad   <= n_rad;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_cnt   <= n_cnt;
        r_scan  <= n_scan;
        r_idx   <= n_idx;
        r_close <= n_close;
        r_best  <= n_best;
        r_dgoal <= n_dgoal;
        r_lval  <= n_lval;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_alpha <= n_alpha;
        r_prod  <= n_prod;
        r_lin   <= n_lin;
        r_sneg  <= n_sneg;
        r_num   <= n_num;
        r_q     <= n_q;
        r_drem  <= n_drem;
        r_olin  <= n_olin;
        r_oang  <= n_oang;
        r_ost   <= n_ost;
    end

endmodule

### rtl/ppf_checker.sv
// ----------------------------------------------------------------------------
// Pure pursuit follower port checker
// Watches the follower's ports for result beats that break its contract.
// ----------------------------------------------------------------------------
`include "pure_pursuit_path_follower_top_assert.svh"

module ppf_checker
    import ppf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_opcode,
    input logic               o_valid,
    input logic signed [20:0] o_linear_cmd,
    input logic signed [21:0] o_angular_cmd,
    input logic [3:0]         o_status
);

    `PPF_ASSERT_NOW(a_stop_zero, o_valid && (o_status != ST_DRIVE), (o_linear_cmd == 21'sd0) && (o_angular_cmd == 22'sd0))
    `PPF_ASSERT_NOW(a_drive_fwd, o_valid && (o_status == ST_DRIVE), !o_linear_cmd[20])
    `PPF_ASSERT_NEXT(a_clear_ack, start && !busy && (i_opcode == OP_CLEAR), o_valid && (o_status == ST_STORED) && !busy)
    `PPF_ASSERT_NEXT(a_append_ack, start && !busy && (i_opcode == OP_APPEND), o_valid && ((o_status == ST_STORED) || (o_status == ST_DROPPED)))
    `PPF_ASSERT_NEXT(a_nop_quiet, start && !busy && (i_opcode == 2'd3), !o_valid && !busy)

endmodule

bind pure_pursuit_path_follower_top ppf_checker u_ppf_checker (.*);
